### rtl/pidwr_pkg.sv
// ----------------------------------------------------------------------------
// pidwr_pkg: shared types and constants of the PID windup-reset unit
// Holds default widths, configuration register codes, the windup threshold
// and the sequencer state type.
// ----------------------------------------------------------------------------
package pidwr_pkg;

    // default fixed-point format and integrator width
    localparam int FRAC_BITS_DEF      = 16;
    localparam int INTEGRAL_WIDTH_DEF = 48;

    // integral threshold (integer part) above which the integral is zeroed
    localparam int WINDUP_LIMIT = 500;

    // the I and D terms saturate at 2**TERM_LIM_LOG2 (fixed point)
    localparam int TERM_LIM_LOG2 = 60;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_P       = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_I       = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_D       = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_CENTER_VALUE = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_TOP_LIMIT    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_BOTTOM_LIMIT = 3'd5;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,     // wait for an input transaction
        S_MUL_P,    // multiply: |gain_p| * |error|
        S_MUL_IL,   // add P term; multiply |gain_i| * low half of |integral|
        S_MUL_IH,   // keep low partial; multiply |gain_i| * high half
        S_MUL_D,    // merge I partials; multiply |gain_d| * |error change|
        S_MUL_E,    // add I term; load divider; multiply |error| * dt
        S_INTEG,    // update integral
        S_DIV,      // restoring divide, one quotient bit per cycle
        S_DADD,     // add D term
        S_TRUNC,    // truncate command toward zero
        S_OUT       // clamp and load output register
    } t_state;

endpackage

### rtl/pid_controller_windup_reset_unit.sv
// ----------------------------------------------------------------------------
// pid_controller_windup_reset_unit: PID position loop with windup reset
// One shared 32x32 multiplier and a bit-serial divider under a sequencer
// compute a clamped integer drive command per input transaction.
//
//   channel  dir  signals          contents (lowest bits first)
//   s_axis   in   tdata[95:0]      goal_value, measured_value, elapsed_time
//                 tuser[0]         integrate_enable
//   m_axis   out  tdata[15:0]      drive_command
//                 tuser[1:0]       clamped_flag, windup_cleared
//   cfg      in   we/addr/wdata    gain_p, gain_i, gain_d, center_value,
//                                  top_limit, bottom_limit (index 0..5)
//
// m_axis_tvalid rises once the sequencer has run the multiplies, the integral
// update, the restoring divide, the D add and the truncation and clamp; the
// divider produces one of its 48 + FRAC_BITS quotient bits per cycle, and with
// elapsed_time zero the divide is skipped. s_axis_tready is high only when the
// sequencer is idle, so the next input is taken at the earliest in the cycle in
// which the result appears. The result sits in an output register, so the next
// transaction is accepted while it waits; a stalled result holds the sequencer
// in its last state. Reset is synchronous, active low, and clears the integral,
// the previous error, the state and the control and configuration registers to their defaults.
// ----------------------------------------------------------------------------
module pid_controller_windup_reset_unit #(
    parameter int FRAC_BITS      = pidwr_pkg::FRAC_BITS_DEF,
    parameter int INTEGRAL_WIDTH = pidwr_pkg::INTEGRAL_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [pidwr_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [pidwr_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    // input stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [95:0]                      s_axis_tdata,  // goal, measured, elapsed_time
    input  logic                             s_axis_tuser,  // integrate_enable
    // output stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [15:0]                      m_axis_tdata,  // drive_command
    output logic [1:0]                       m_axis_tuser   // clamped_flag, windup_cleared
);
    import pidwr_pkg::*;

    localparam int IW    = INTEGRAL_WIDTH;
    localparam int DIVN  = 48 + FRAC_BITS;          // dividend bits: |num| << FRAC_BITS
    localparam int CNT_W = $clog2(DIVN);

    localparam logic signed [IW-1:0] WINDUP_THR = IW'(WINDUP_LIMIT) << FRAC_BITS;
    localparam logic [79:0]          TERM_LIM   = 80'd1 << TERM_LIM_LOG2;
    localparam logic signed [65:0]   INT_HI     = (66'sd1 <<< (IW - 1)) - 66'sd1;
    localparam logic signed [65:0]   INT_LO     = -INT_HI - 66'sd1;

    // control and loop state (reset)
    t_state                r_state, n_state;
    logic                  r_out_valid, n_out_valid;
    logic signed [IW-1:0]  r_integral, n_integral;
    logic signed [31:0]    r_prev_err, n_prev_err;
    logic [CNT_W-1:0]      r_cnt, n_cnt;

    // configuration registers
    logic signed [15:0]    r_gain_p, r_gain_i, r_gain_d;
    logic signed [31:0]    r_center;
    logic signed [15:0]    r_top_limit, r_bottom_limit;

    // datapath registers
    logic signed [31:0]    r_err, n_err;
    logic signed [32:0]    r_diff, n_diff;
    logic [31:0]           r_dt, n_dt;
    logic                  r_en, n_en;
    logic                  r_wind, n_wind;
    logic [63:0]           r_prod, n_prod;
    logic signed [63:0]    r_sum, n_sum;
    logic [79:0]           r_iacc, n_iacc;
    logic [DIVN-1:0]       r_dq, n_dq;
    logic [32:0]           r_rem, n_rem;
    logic signed [63:0]    r_cmd, n_cmd;
    logic [15:0]           r_out_data, n_out_data;
    logic [1:0]            r_out_user, n_out_user;

    assign s_axis_tready = (r_state == S_IDLE) && i_rst_n;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    // sequencer and datapath next values
    always_comb begin
        logic signed [32:0] in_diff;
        logic signed [31:0] err_sat;
        logic [15:0]        gp_mag, gi_mag, gd_mag;
        logic [31:0]        err_mag, diff_mag;
        logic [32:0]        diff_mag33;
        logic signed [63:0] int_ext, center_ext;
        logic [63:0]        int_mag;
        logic               p_neg, i_neg, d_neg;
        logic [31:0]        op_a, op_b;
        logic [79:0]        i_sat, d_sat;
        logic [63:0]        incr;
        logic signed [65:0] int_sum, int_clamp;
        logic [32:0]        trial;
        logic               ge;
        logic [63:0]        sum_mag, cmd_mag;
        logic signed [63:0] top_ext, bot_ext, c1, c2;
        logic               f1, f2;

        n_state     = r_state;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_integral  = r_integral;
        n_prev_err  = r_prev_err;
        n_cnt       = r_cnt;
        n_err       = r_err;
        n_diff      = r_diff;
        n_dt        = r_dt;
        n_en        = r_en;
        n_wind      = r_wind;
        n_sum       = r_sum;
        n_iacc      = r_iacc;
        n_dq        = r_dq;
        n_rem       = r_rem;
        n_cmd       = r_cmd;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;

        // error from the incoming transaction, saturated to 32 bits
        in_diff = 33'(signed'(s_axis_tdata[31:0])) - 33'(signed'(s_axis_tdata[63:32]));
        if (in_diff > 33'sd2147483647) begin
            err_sat = 32'sh7FFF_FFFF;
        end else if (in_diff < -33'sd2147483648) begin
            err_sat = 32'sh8000_0000;
        end else begin
            err_sat = in_diff[31:0];
        end

        // operand magnitudes and term signs
        gp_mag     = r_gain_p[15] ? 16'(-r_gain_p) : r_gain_p;
        gi_mag     = r_gain_i[15] ? 16'(-r_gain_i) : r_gain_i;
        gd_mag     = r_gain_d[15] ? 16'(-r_gain_d) : r_gain_d;
        err_mag    = r_err[31] ? 32'(-r_err) : r_err;
        diff_mag33 = r_diff[32] ? 33'(-r_diff) : r_diff;
        diff_mag   = diff_mag33[31:0];
        int_ext    = 64'(r_integral);
        int_mag    = int_ext[63] ? 64'(-int_ext) : int_ext;
        center_ext = 64'(r_center);
        p_neg      = r_gain_p[15] ^ r_err[31];
        i_neg      = r_gain_i[15] ^ r_integral[IW-1];
        d_neg      = r_gain_d[15] ^ r_diff[32];

        // shared multiplier operand select
        unique case (r_state)
            S_MUL_P:  begin op_a = 32'(gp_mag); op_b = err_mag;        end
            S_MUL_IL: begin op_a = 32'(gi_mag); op_b = int_mag[31:0];  end
            S_MUL_IH: begin op_a = 32'(gi_mag); op_b = int_mag[63:32]; end
            S_MUL_D:  begin op_a = 32'(gd_mag); op_b = diff_mag;       end
            S_MUL_E:  begin op_a = err_mag;     op_b = r_dt;           end
            default:  begin op_a = '0;          op_b = '0;             end
        endcase
        n_prod = op_a * op_b;

        // saturated term magnitudes
        i_sat = (r_iacc > TERM_LIM) ? TERM_LIM : r_iacc;
        d_sat = (80'(r_dq) > TERM_LIM) ? TERM_LIM : 80'(r_dq);

        // integral update with saturation to the integrator range
        incr    = r_prod >> FRAC_BITS;
        int_sum = r_err[31] ? (66'(int_ext) - signed'(66'(incr)))
                            : (66'(int_ext) + signed'(66'(incr)));
        if (int_sum > INT_HI) begin
            int_clamp = INT_HI;
        end else if (int_sum < INT_LO) begin
            int_clamp = INT_LO;
        end else begin
            int_clamp = int_sum;
        end

        // one restoring division step
        trial = {r_rem[31:0], r_dq[DIVN-1]};
        ge    = trial >= {1'b0, r_dt};

        // truncation toward zero
        sum_mag = r_sum[63] ? 64'(-r_sum) : r_sum;
        cmd_mag = sum_mag >> FRAC_BITS;

        // clamp: top first, then bottom
        top_ext = 64'(r_top_limit);
        bot_ext = 64'(r_bottom_limit);
        f1      = r_cmd > top_ext;
        c1      = f1 ? top_ext : r_cmd;
        f2      = c1 < bot_ext;
        c2      = f2 ? bot_ext : c1;

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_err      = err_sat;
                    n_diff     = 33'(err_sat) - 33'(r_prev_err);
                    n_prev_err = err_sat;
                    n_dt       = s_axis_tdata[95:64];
                    n_en       = s_axis_tuser;
                    n_wind     = r_integral > WINDUP_THR;
                    if (r_integral > WINDUP_THR) begin
                        n_integral = '0;
                    end
                    n_state = S_MUL_P;
                end
            end
            S_MUL_P: begin
                n_state = S_MUL_IL;
            end
            S_MUL_IL: begin
                // center minus the proportional term
                n_sum   = p_neg ? (center_ext + signed'(r_prod))
                                : (center_ext - signed'(r_prod));
                n_state = S_MUL_IH;
            end
            S_MUL_IH: begin
                n_iacc  = 80'(r_prod);
                n_state = S_MUL_D;
            end
            S_MUL_D: begin
                n_iacc  = r_iacc + {r_prod[47:0], 32'h0};
                n_state = S_MUL_E;
            end
            S_MUL_E: begin
                n_sum   = i_neg ? (r_sum - signed'(i_sat[63:0]))
                                : (r_sum + signed'(i_sat[63:0]));
                n_dq    = (r_dt == '0) ? '0 : {r_prod[47:0], {FRAC_BITS{1'b0}}};
                n_rem   = '0;
                n_cnt   = '0;
                n_state = S_INTEG;
            end
            S_INTEG: begin
                n_integral = r_en ? int_clamp[IW-1:0] : '0;
                n_state    = (r_dt != '0) ? S_DIV : S_DADD;
            end
            S_DIV: begin
                n_rem = ge ? (trial - {1'b0, r_dt}) : trial;
                n_dq  = {r_dq[DIVN-2:0], ge};
                n_cnt = CNT_W'(r_cnt + 1'b1);
                if (r_cnt == CNT_W'(DIVN - 1)) begin
                    n_state = S_DADD;
                end
            end
            S_DADD: begin
                n_sum   = d_neg ? (r_sum - signed'(d_sat[63:0]))
                                : (r_sum + signed'(d_sat[63:0]));
                n_state = S_TRUNC;
            end
            S_TRUNC: begin
                n_cmd   = r_sum[63] ? 64'(-signed'(cmd_mag)) : signed'(cmd_mag);
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = c2[15:0];
                    n_out_user  = {r_wind, f1 | f2};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control, loop state and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_out_valid    <= 1'b0;
            r_integral     <= '0;
            r_prev_err     <= '0;
            r_cnt          <= '0;
            r_gain_p       <= '0;
            r_gain_i       <= '0;
            r_gain_d       <= '0;
            r_center       <= '0;
            r_top_limit    <= 16'sh7FFF;
            r_bottom_limit <= 16'sh8000;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_integral  <= n_integral;
            r_prev_err  <= n_prev_err;
            r_cnt       <= n_cnt;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_GAIN_P:       r_gain_p       <= i_cfg_wdata[15:0];
                    CFG_GAIN_I:       r_gain_i       <= i_cfg_wdata[15:0];
                    CFG_GAIN_D:       r_gain_d       <= i_cfg_wdata[15:0];
                    CFG_CENTER_VALUE: r_center       <= i_cfg_wdata;
                    CFG_TOP_LIMIT:    r_top_limit    <= i_cfg_wdata[15:0];
                    CFG_BOTTOM_LIMIT: r_bottom_limit <= i_cfg_wdata[15:0];
                    default: ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_err      <= n_err;
        r_diff     <= n_diff;
        r_dt       <= n_dt;
        r_en       <= n_en;
        r_wind     <= n_wind;
        r_prod     <= n_prod;
        r_sum      <= n_sum;
        r_iacc     <= n_iacc;
        r_dq       <= n_dq;
        r_rem      <= n_rem;
        r_cmd      <= n_cmd;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
    end

endmodule

### rtl/pidwr_checker.sv
// ----------------------------------------------------------------------------
// pidwr_checker: port-level checks for the PID windup-reset unit
// Watches the stream ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
module pidwr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // reset empties the output register
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

    // one transaction at a time: input closes right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input ready right after accept");

    // a result never appears in the cycle after its transaction is accepted
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && !m_axis_tvalid) |=> !m_axis_tvalid)
        else $error("result appeared too early");

endmodule

bind pid_controller_windup_reset_unit pidwr_checker u_pidwr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the PID windup-reset unit
// Feeds control samples on the input stream and predicts each drive command
// with a cycle-free model of the control law (saturated error, windup reset,
// saturated P/I/D terms, truncation, top/bottom clamp, integral update).
// A short directed table covers reset values, limits, truncation, windup and gain extremes;
// random samples follow under several register settings and idle patterns.
// ----------------------------------------------------------------------------
module tb_top;
    import pidwr_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int TAIL_CYCLES    = 100;
    localparam int MAX_REPORTS    = 10;
    localparam int RAND_BLOCKS    = 9;
    localparam int BLOCK_ITEMS    = 100;

    localparam longint unsigned TERM_CAP = 64'd1 << TERM_LIM_LOG2;
    localparam longint ERR_MAX    = 64'sd2147483647;
    localparam longint ERR_MIN    = -64'sd2147483648;
    localparam longint INTEG_MAX  = (64'sd1 <<< (INTEGRAL_WIDTH_DEF - 1)) - 1;
    localparam longint INTEG_MIN  = -INTEG_MAX - 1;
    localparam longint WINDUP_FIX = longint'(WINDUP_LIMIT) <<< FRAC_BITS_DEF;

    // one control sample and one drive result
    typedef struct packed {
        logic [31:0] goal;
        logic [31:0] meas;
        logic        en;
        logic [31:0] dt;
    } ctrl_sample_t;

    typedef struct packed {
        logic [15:0] cmd;
        logic        clamped;
        logic        wind;
    } drive_result_t;

    // hand-written result that travels with a sample until it is accepted
    typedef struct packed {
        bit            known;
        drive_result_t res;
    } known_result_t;

    typedef struct {
        bit                    is_cfg;
        logic [CFG_ADDR_W-1:0] addr;
        logic [31:0]           data;
        ctrl_sample_t          smp;
        bit                    known;
        drive_result_t         res;
    } table_row_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [95:0]           s_axis_tdata = '0;  // goal, measured, elapsed_time
    logic                  s_axis_tuser = 1'b0; // integrate_enable
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [15:0]           m_axis_tdata;       // drive_command
    logic [1:0]            m_axis_tuser;       // clamped_flag, windup_cleared

    pid_controller_windup_reset_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // model state and register copies
    longint model_integral = 0;
    longint model_prev_err = 0;
    longint model_kp = 0, model_ki = 0, model_kd = 0, model_center = 0;
    longint model_top = 32767, model_bottom = -32768;

    drive_result_t drive_expect_q[$];
    known_result_t known_q[$];
    table_row_t    directed_rows[$];

    int src_idle_pct = 22;
    int snk_idle_pct = 52;
    int n_sent = 0;
    int n_out = 0;
    int fail_count = 0;
    int wind_seen = 0;
    int clamp_seen = 0;
    int idle_cycles = 0;

    // ------------------------------------------------------------------------
    // Control law helpers
    // ------------------------------------------------------------------------
    function automatic longint unsigned magnitude(input longint v);
        if (v < 0) return -v;
        return v;
    endfunction

    function automatic longint with_sign(input longint unsigned m, input bit neg);
        return neg ? -longint'(m) : longint'(m);
    endfunction

    // gain times value, magnitude capped at the term limit
    function automatic longint sat_product(input longint a, input longint b);
        longint unsigned p;
        p = magnitude(a) * magnitude(b);
        if (p > TERM_CAP) p = TERM_CAP;
        return with_sign(p, (a < 0) != (b < 0));
    endfunction

    // derivative: num/dt in fixed point, truncated toward zero, capped
    function automatic longint rate_term(input longint num, input longint unsigned dt);
        longint unsigned m, q, r, res;
        if (dt == 0) return 0;
        m = magnitude(num);
        q = m / dt;
        r = m % dt;
        if (q >= (TERM_CAP >> FRAC_BITS_DEF))
            res = TERM_CAP;
        else
            res = (q << FRAC_BITS_DEF) + ((r << FRAC_BITS_DEF) / dt);
        if (res > TERM_CAP) res = TERM_CAP;
        return with_sign(res, num < 0);
    endfunction

    // one controller step: returns the result and advances the model state
    function automatic drive_result_t pid_command_model(input ctrl_sample_t smp);
        drive_result_t res;
        longint err, sum, cmd, incr;
        res = '0;
        err = longint'($signed(smp.goal)) - longint'($signed(smp.meas));
        if (err > ERR_MAX) err = ERR_MAX;
        if (err < ERR_MIN) err = ERR_MIN;

        // windup reset happens before the integral is used
        if (model_integral > WINDUP_FIX) begin
            model_integral = 0;
            res.wind = 1'b1;
        end

        sum = model_center
            - sat_product(model_kp, err)
            + sat_product(model_ki, model_integral)
            + rate_term(model_kd * (err - model_prev_err), 64'(smp.dt));

        cmd = with_sign(magnitude(sum) >> FRAC_BITS_DEF, sum < 0);
        if (cmd > model_top) begin
            cmd = model_top;
            res.clamped = 1'b1;
        end
        if (cmd < model_bottom) begin
            cmd = model_bottom;
            res.clamped = 1'b1;
        end
        res.cmd = 16'(cmd);
        model_prev_err = err;

        // integral update after the command
        if (smp.en) begin
            incr = with_sign((magnitude(err) * 64'(smp.dt)) >> FRAC_BITS_DEF, err < 0);
            model_integral = model_integral + incr;
            if (model_integral > INTEG_MAX) model_integral = INTEG_MAX;
            if (model_integral < INTEG_MIN) model_integral = INTEG_MIN;
        end else begin
            model_integral = 0;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Directed table builders
    // ------------------------------------------------------------------------
    function automatic void add_cfg(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
        table_row_t row;
        row = '{default: '0};
        row.is_cfg = 1'b1;
        row.addr = addr;
        row.data = data;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_predicted(input logic [31:0] goal, input logic [31:0] meas,
                                          input logic en, input logic [31:0] dt);
        table_row_t row;
        row = '{default: '0};
        row.smp = '{goal: goal, meas: meas, en: en, dt: dt};
        directed_rows.push_back(row);
    endfunction

    function automatic void add_checked(input logic [31:0] goal, input logic [31:0] meas,
                                        input logic en, input logic [31:0] dt,
                                        input logic [15:0] cmd, input logic clamped,
                                        input logic wind);
        table_row_t row;
        row = '{default: '0};
        row.smp = '{goal: goal, meas: meas, en: en, dt: dt};
        row.known = 1'b1;
        row.res = '{cmd: cmd, clamped: clamped, wind: wind};
        directed_rows.push_back(row);
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    // present one sample and hold it until the transaction completes
    task automatic push_sample(input ctrl_sample_t smp, input known_result_t tag);
        i_cfg_we <= 1'b0;
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {smp.dt, smp.meas, smp.goal};
        s_axis_tuser  <= smp.en;
        known_q.push_back(tag);
        do @(posedge i_clk); while (!s_axis_tready);
        n_sent++;
    endtask

    // stop sending and wait for every pending result
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (n_out < n_sent);
    endtask

    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
    endtask

    // program all registers: small gains, full random, or extremes
    task automatic apply_setting(input int style);
        int kp, ki, kd, ctr, top, bot;
        drain_results();
        case (style)
            0: begin
                kp  = int'($urandom_range(16)) - 8;
                ki  = int'($urandom_range(16)) - 8;
                kd  = int'($urandom_range(16)) - 8;
                ctr = int'($urandom_range(32'h0200_0000)) - 32'sh0100_0000;
                top = int'($urandom_range(3000));
                bot = -int'($urandom_range(3000));
            end
            1: begin
                kp  = int'($signed(16'($urandom)));
                ki  = int'($signed(16'($urandom)));
                kd  = int'($signed(16'($urandom)));
                ctr = int'($urandom);
                top = int'($signed(16'($urandom)));
                bot = int'($signed(16'($urandom)));
            end
            default: begin
                kp  = $urandom_range(1) ? 32767 : -32768;
                ki  = $urandom_range(1) ? 32767 : -32768;
                kd  = $urandom_range(1) ? 32767 : -32768;
                ctr = $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
                top = $urandom_range(1) ? 32767 : -32768;
                bot = (top == 32767) ? -32768 : 32767;
            end
        endcase
        cfg_write(CFG_GAIN_P, 32'(kp));
        cfg_write(CFG_GAIN_I, 32'(ki));
        cfg_write(CFG_GAIN_D, 32'(kd));
        cfg_write(CFG_CENTER_VALUE, 32'(ctr));
        cfg_write(CFG_TOP_LIMIT, 32'(top));
        cfg_write(CFG_BOTTOM_LIMIT, 32'(bot));
    endtask

    // random sample: mostly small errors and short steps, some wide ones
    function automatic ctrl_sample_t rand_sample();
        ctrl_sample_t smp;
        int pick;
        smp.goal = $urandom;
        if ($urandom_range(9) < 3)
            smp.meas = $urandom;
        else
            smp.meas = smp.goal - 32'($urandom_range(32'h0020_0000)) + 32'h0010_0000;
        pick = $urandom_range(99);
        if (pick < 8)
            smp.dt = '0;
        else if (pick < 12)
            smp.dt = 32'hFFFF_FFFF;
        else if (pick < 25)
            smp.dt = $urandom;
        else if (pick < 30)
            smp.dt = $urandom_range(1, 16);
        else
            smp.dt = $urandom_range(1, 32'h0003_0000);
        smp.en = ($urandom_range(99) < 85);
        return smp;
    endfunction

    task automatic flag_mismatch(input string what, input drive_result_t want,
                                 input drive_result_t got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("[%0t] %s: expected cmd=%0d clamp=%0b wind=%0b, got cmd=%0d clamp=%0b wind=%0b",
                     $realtime, what, $signed(want.cmd), want.clamped, want.wind,
                     $signed(got.cmd), got.clamped, got.wind);
    endtask

    // ------------------------------------------------------------------------
    // Monitor: result check, prediction on accept, register shadow, watchdog
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        drive_result_t got, want;
        known_result_t tag;
        ctrl_sample_t smp;
        bit moved;
        moved = 1'b0;
        if (i_rst_n) begin
            // output transaction
            if (m_axis_tvalid && m_axis_tready) begin
                moved = 1'b1;
                n_out++;
                got.cmd = m_axis_tdata;
                got.clamped = m_axis_tuser[0];
                got.wind = m_axis_tuser[1];
                if (drive_expect_q.size() == 0) begin
                    flag_mismatch("unexpected result", '0, got);
                end else begin
                    want = drive_expect_q.pop_front();
                    if (got.cmd !== want.cmd) flag_mismatch("drive_command", want, got);
                    if (got.clamped !== want.clamped) flag_mismatch("clamped_flag", want, got);
                    if (got.wind !== want.wind) flag_mismatch("windup_cleared", want, got);
                    if (want.wind) wind_seen++;
                    if (want.clamped) clamp_seen++;
                end
            end
            // input transaction
            if (s_axis_tvalid && s_axis_tready) begin
                moved = 1'b1;
                smp.goal = s_axis_tdata[31:0];
                smp.meas = s_axis_tdata[63:32];
                smp.dt = s_axis_tdata[95:64];
                smp.en = s_axis_tuser;
                want = pid_command_model(smp);
                tag = (known_q.size() != 0) ? known_q.pop_front() : '0;
                drive_expect_q.push_back(tag.known ? tag.res : want);
            end
            // register shadow
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_GAIN_P:       model_kp = longint'($signed(i_cfg_wdata[15:0]));
                    CFG_GAIN_I:       model_ki = longint'($signed(i_cfg_wdata[15:0]));
                    CFG_GAIN_D:       model_kd = longint'($signed(i_cfg_wdata[15:0]));
                    CFG_CENTER_VALUE: model_center = longint'($signed(i_cfg_wdata[31:0]));
                    CFG_TOP_LIMIT:    model_top = longint'($signed(i_cfg_wdata[15:0]));
                    CFG_BOTTOM_LIMIT: model_bottom = longint'($signed(i_cfg_wdata[15:0]));
                    default: ;
                endcase
            end
            if (moved) idle_cycles = 0;
            else idle_cycles++;
        end
        m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        known_result_t tag;
        bit last_was_item;

        // reset values with zero gains
        add_checked(32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 32'h0000_0000, 16'd0, 1'b0, 1'b0);
        add_checked(32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 32'hFFFF_FFFF, 16'd0, 1'b0, 1'b0);
        // center extremes land exactly on the default limits
        add_cfg(CFG_CENTER_VALUE, 32'h7FFF_FFFF);
        add_checked(32'h0, 32'h0, 1'b0, 32'h0001_0000, 16'h7FFF, 1'b0, 1'b0);
        add_cfg(CFG_CENTER_VALUE, 32'h8000_0000);
        add_checked(32'h0, 32'h0, 1'b0, 32'h0001_0000, 16'h8000, 1'b0, 1'b0);
        // narrow limits, both sides
        add_cfg(CFG_TOP_LIMIT, 32'd100);
        add_cfg(CFG_BOTTOM_LIMIT, -32'sd100);
        add_checked(32'h0, 32'h0, 1'b0, 32'h0001_0000, -16'sd100, 1'b1, 1'b0);
        add_cfg(CFG_CENTER_VALUE, 32'h7FFF_FFFF);
        add_checked(32'h0, 32'h0, 1'b0, 32'h0001_0000, 16'd100, 1'b1, 1'b0);
        // crossed limits: bottom wins
        add_cfg(CFG_TOP_LIMIT, -32'sd50);
        add_cfg(CFG_BOTTOM_LIMIT, 32'd50);
        add_cfg(CFG_CENTER_VALUE, 32'h0);
        add_checked(32'h0, 32'h0, 1'b0, 32'h0001_0000, 16'd50, 1'b1, 1'b0);
        // -1.5 truncates toward zero
        add_cfg(CFG_TOP_LIMIT, 32'd32767);
        add_cfg(CFG_BOTTOM_LIMIT, -32'sd32768);
        add_cfg(CFG_CENTER_VALUE, 32'hFFFE_8000);
        add_checked(32'h0, 32'h0, 1'b0, 32'h0001_0000, 16'hFFFF, 1'b0, 1'b0);
        // windup: 1000.0 clears, exactly 500.0 stays, one LSB above clears
        add_cfg(CFG_CENTER_VALUE, 32'h0002_8000);
        add_checked(32'h03E8_0000, 32'h0, 1'b1, 32'h0001_0000, 16'd2, 1'b0, 1'b0);
        add_checked(32'h0, 32'h0, 1'b0, 32'h0001_0000, 16'd2, 1'b0, 1'b1);
        add_checked(32'h01F4_0000, 32'h0, 1'b1, 32'h0001_0000, 16'd2, 1'b0, 1'b0);
        add_checked(32'h0, 32'h0, 1'b1, 32'h0001_0000, 16'd2, 1'b0, 1'b0);
        add_checked(32'h1, 32'h0, 1'b1, 32'h0001_0000, 16'd2, 1'b0, 1'b0);
        add_checked(32'h0, 32'h0, 1'b0, 32'h0000_0000, 16'd2, 1'b0, 1'b1);
        // gain extremes, integral saturation, derivative cap
        add_cfg(CFG_CENTER_VALUE, 32'h0);
        add_cfg(CFG_GAIN_P, 32'hFFFF_8000);
        add_cfg(CFG_GAIN_I, 32'h0000_7FFF);
        add_cfg(CFG_GAIN_D, 32'h0000_7FFF);
        add_predicted(32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 32'hFFFF_FFFF);
        add_predicted(32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 32'hFFFF_FFFF);
        add_predicted(32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 32'hFFFF_FFFF);
        add_predicted(32'h0, 32'h0, 1'b1, 32'h0000_0001);
        add_cfg(CFG_GAIN_P, 32'h0000_7FFF);
        add_cfg(CFG_GAIN_I, 32'hFFFF_8000);
        add_cfg(CFG_GAIN_D, 32'hFFFF_8000);
        add_predicted(32'h1234_5678, 32'hEDCB_A987, 1'b1, 32'h0000_8000);
        add_predicted(32'hFFFF_FFFF, 32'h0, 1'b0, 32'h0000_0000);
        add_predicted(32'h0, 32'hFFFF_FFFF, 1'b1, 32'h0000_0003);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        last_was_item = 1'b0;
        foreach (directed_rows[k]) begin
            if (directed_rows[k].is_cfg) begin
                if (last_was_item) drain_results();
                cfg_write(directed_rows[k].addr, directed_rows[k].data);
                last_was_item = 1'b0;
            end else begin
                tag.known = directed_rows[k].known;
                tag.res = directed_rows[k].res;
                push_sample(directed_rows[k].smp, tag);
                last_was_item = 1'b1;
            end
        end

        // random part: three idle patterns, three register settings each
        tag = '0;
        for (int blk = 0; blk < RAND_BLOCKS; blk++) begin
            if (blk == RAND_BLOCKS / 3) begin
                src_idle_pct = 52;
                snk_idle_pct = 22;
            end else if (blk == 2 * RAND_BLOCKS / 3) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            apply_setting(blk % 3);
            for (int n = 0; n < BLOCK_ITEMS; n++) begin
                push_sample(rand_sample(), tag);
                if ($urandom_range(49) == 0) drain_results();
            end
        end

        // wind down and look for stray results
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (drive_expect_q.size() != 0) begin
            $display("%0d expected results never arrived", drive_expect_q.size());
            fail_count += drive_expect_q.size();
        end

        $display("Covered %0d control samples and %0d drive results under %0d register settings",
                 n_sent, n_out, RAND_BLOCKS + 6);
        $display("Results with windup reset: %0d, with clamped command: %0d",
                 wind_seen, clamp_seen);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/pidwr_pkg.sv
rtl/pid_controller_windup_reset_unit.sv
rtl/pidwr_checker.sv
verif/tb_top.sv
